FILE: design/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tsv_pkg.sv
// Package with the types, codes and constants of the tolerance voter.
package tsv_pkg;

   localparam int unsigned READING_W = 16;
   localparam int unsigned TOL_W     = 15;
   localparam int unsigned SUM_W     = 18;
   localparam int unsigned MAG_W     = 17;
   localparam int unsigned RECIP_W   = 17;
   localparam int unsigned PROD_W    = MAG_W + RECIP_W;
   localparam int unsigned DIV3_SHIFT = 18;

   // ceil(2^18 / 3); exact for every magnitude below 2^17.
   localparam logic [RECIP_W-1:0] DIV3_RECIP = 17'd87382;

   localparam logic [TOL_W-1:0] TOLERANCE_RESET = 15'd10;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TOLERANCE = 2'd0;

   typedef enum logic [1:0] {
      VOTE_OK           = 2'd0,
      VOTE_SENSOR_ERROR = 2'd1,
      VOTE_DISAGREE     = 2'd2
   } vote_status_type;

   typedef struct packed {
      logic signed [READING_W-1:0] reading_a;
      logic                        valid_a;
      logic signed [READING_W-1:0] reading_b;
      logic                        valid_b;
      logic signed [READING_W-1:0] reading_c;
      logic                        valid_c;
   } req_payload_type;

   typedef struct packed {
      vote_status_type             vote_status;
      logic                        agree_a;
      logic                        agree_b;
      logic                        agree_c;
      logic signed [READING_W-1:0] echo_a;
      logic signed [READING_W-1:0] echo_b;
      logic signed [READING_W-1:0] echo_c;
      logic signed [READING_W-1:0] voted_average;
   } rsp_payload_type;

   // First pipeline stage: pairwise comparisons and gated readings.
   typedef struct packed {
      logic [2:0]                  present;
      logic                        close_ab;
      logic                        close_bc;
      logic                        close_ca;
      logic signed [READING_W-1:0] echo_a;
      logic signed [READING_W-1:0] echo_b;
      logic signed [READING_W-1:0] echo_c;
   } s1_type;

   // Second pipeline stage: vote decision and sum magnitude.
   typedef struct packed {
      vote_status_type             vote_status;
      logic                        agree_a;
      logic                        agree_b;
      logic                        agree_c;
      logic signed [READING_W-1:0] echo_a;
      logic signed [READING_W-1:0] echo_b;
      logic signed [READING_W-1:0] echo_c;
      logic                        negative;
      logic                        by_three;
      logic [MAG_W-1:0]            magnitude;
   } s2_type;

endpackage

FILE: design/triple_sensor_tolerance_voter_unit.sv
// Top level of the two-of-three tolerance voter with its register port.
// Throughput: one transaction per clock cycle, sustained, while rsp_stall is low.
// Three register stages: compare lanes, merge, divide-and-sign. The edge that
// accepts the request loads the first; rsp_valid rises when the third is loaded.
// Reset is synchronous and active high: it empties the pipeline and sets the
// tolerance register to 10. Data registers keep their contents through reset.
module triple_sensor_tolerance_voter_unit
   import tsv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration register. Writes land on the access phase of an APB write.
   logic [TOL_W-1:0] tolerance_ff;
   logic [TOL_W-1:0] tolerance_in;

   assign pready = 1'b1;

   always_comb begin
      tolerance_in = tolerance_ff;
      if (psel && penable && pwrite && (paddr == ADDR_TOLERANCE)) begin
         tolerance_in = pwdata[TOL_W-1:0];
      end
   end

   assign prdata = (paddr == ADDR_TOLERANCE) ? {{(CSR_DATA_W-TOL_W){1'b0}}, tolerance_ff} : '0;

   // Pipeline occupancy. Each stage advances whenever the stage after it has
   // room, so bubbles collapse and a waiting result does not block intake
   // unless every stage is full.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic s2_valid_ff;
   logic s2_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_ready;
   logic s2_ready;
   logic s1_ready;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   // No request is taken while reset is held, so the intake reports a stall then.
   assign req_stall = !s1_ready || reset;

   assign s1_valid_in  = s1_ready  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

   // Stage one: three comparison lanes, one per reading pair, run side by side.
   s1_type s1_ff;
   s1_type s1_in;
   logic   close_ab;
   logic   close_bc;
   logic   close_ca;

   tsv_pair_lane u_lane_ab (
      .x_reading (req_payload.reading_a),
      .x_valid   (req_payload.valid_a),
      .y_reading (req_payload.reading_b),
      .y_valid   (req_payload.valid_b),
      .tolerance (tolerance_ff),
      .close     (close_ab)
   );

   tsv_pair_lane u_lane_bc (
      .x_reading (req_payload.reading_b),
      .x_valid   (req_payload.valid_b),
      .y_reading (req_payload.reading_c),
      .y_valid   (req_payload.valid_c),
      .tolerance (tolerance_ff),
      .close     (close_bc)
   );

   tsv_pair_lane u_lane_ca (
      .x_reading (req_payload.reading_c),
      .x_valid   (req_payload.valid_c),
      .y_reading (req_payload.reading_a),
      .y_valid   (req_payload.valid_a),
      .tolerance (tolerance_ff),
      .close     (close_ca)
   );

   // Invalid readings are replaced by zero here, so later stages can sum
   // and echo them without looking at the valid flags again.
   always_comb begin
      s1_in.present  = {req_payload.valid_a, req_payload.valid_b, req_payload.valid_c};
      s1_in.close_ab = close_ab;
      s1_in.close_bc = close_bc;
      s1_in.close_ca = close_ca;
      s1_in.echo_a   = req_payload.valid_a ? req_payload.reading_a : '0;
      s1_in.echo_b   = req_payload.valid_b ? req_payload.reading_b : '0;
      s1_in.echo_c   = req_payload.valid_c ? req_payload.reading_c : '0;
   end

   // Stage two: the merge combines the lane flags into agree flags and the
   // status, and forms the magnitude of the sum of the agreeing readings.
   s2_type s2_ff;
   s2_type s2_in;

   tsv_merge u_merge (
      .s1 (s1_ff),
      .s2 (s2_in)
   );

   // Stage three: divide by the number of agreeing readings, truncating
   // toward zero, and place the result in the output register.
   rsp_payload_type out_ff;
   rsp_payload_type out_in;

   tsv_scale u_scale (
      .s2  (s2_ff),
      .rsp (out_in)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tolerance_ff <= tolerance_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Data registers load only when their stage advances with a live transaction.
   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s2_valid_ff && out_ready) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: design/tsv_pair_lane.sv
// One comparison lane: checks whether two valid readings lie within tolerance.
module tsv_pair_lane
   import tsv_pkg::*;
(
   input  logic signed [READING_W-1:0] x_reading,
   input  logic                        x_valid,
   input  logic signed [READING_W-1:0] y_reading,
   input  logic                        y_valid,
   input  logic [TOL_W-1:0]            tolerance,
   output logic                        close
);

   logic signed [READING_W:0] diff;
   logic [READING_W:0]        mag;

   // The difference is taken one bit wider so it can never wrap.
   assign diff = {x_reading[READING_W-1], x_reading} - {y_reading[READING_W-1], y_reading};
   assign mag  = diff[READING_W] ? 17'(-diff) : 17'(diff);
   assign close = x_valid && y_valid && (mag <= {2'b00, tolerance});

endmodule

FILE: design/tsv_merge.sv
// Merge stage: combines the lane results into agree flags, status and sum.
module tsv_merge
   import tsv_pkg::*;
(
   input  s1_type s1,
   output s2_type s2
);

   logic [1:0]         n_valid;
   logic [1:0]         n_agree;
   logic               ag_a;
   logic               ag_b;
   logic               ag_c;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   sum_neg;
   logic [SUM_W-1:0]   term_a;
   logic [SUM_W-1:0]   term_b;
   logic [SUM_W-1:0]   term_c;

   assign n_valid = 2'($countones(s1.present));

   // A lane only reports close when both of its readings are valid.
   assign ag_a = (n_valid >= 2'd2) && (s1.close_ab || s1.close_ca);
   assign ag_b = (n_valid >= 2'd2) && (s1.close_ab || s1.close_bc);
   assign ag_c = (n_valid >= 2'd2) && (s1.close_bc || s1.close_ca);
   assign n_agree = 2'($countones({ag_a, ag_b, ag_c}));

   assign term_a = ag_a ? {{2{s1.echo_a[READING_W-1]}}, s1.echo_a} : '0;
   assign term_b = ag_b ? {{2{s1.echo_b[READING_W-1]}}, s1.echo_b} : '0;
   assign term_c = ag_c ? {{2{s1.echo_c[READING_W-1]}}, s1.echo_c} : '0;
   assign sum     = term_a + term_b + term_c;
   assign sum_neg = -sum;

   always_comb begin
      s2.agree_a  = ag_a;
      s2.agree_b  = ag_b;
      s2.agree_c  = ag_c;
      s2.echo_a   = s1.echo_a;
      s2.echo_b   = s1.echo_b;
      s2.echo_c   = s1.echo_c;
      s2.negative = sum[SUM_W-1];
      s2.by_three = (n_agree == 2'd3);
      s2.magnitude = sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
      priority if (n_valid < 2'd2) begin
         s2.vote_status = VOTE_SENSOR_ERROR;
         s2.magnitude   = '0;
      end else if (n_agree < 2'd2) begin
         s2.vote_status = VOTE_DISAGREE;
         s2.magnitude   = '0;
      end else begin
         s2.vote_status = VOTE_OK;
      end
   end

endmodule

FILE: design/tsv_scale.sv
// Averaging stage: divides the sum magnitude by two or three and restores the sign.
module tsv_scale
   import tsv_pkg::*;
(
   input  s2_type          s2,
   output rsp_payload_type rsp
);

   logic [PROD_W-1:0]    product;
   logic [READING_W-1:0] quotient;
   logic [READING_W-1:0] quotient_neg;

   // Division by three is a multiply by the rounded-up reciprocal.
   assign product = {{RECIP_W{1'b0}}, s2.magnitude} * {{MAG_W{1'b0}}, DIV3_RECIP};
   assign quotient = s2.by_three ? product[DIV3_SHIFT+READING_W-1:DIV3_SHIFT]
                                 : s2.magnitude[MAG_W-1:1];
   assign quotient_neg = -quotient;

   always_comb begin
      rsp.vote_status   = s2.vote_status;
      rsp.agree_a       = s2.agree_a;
      rsp.agree_b       = s2.agree_b;
      rsp.agree_c       = s2.agree_c;
      rsp.echo_a        = s2.echo_a;
      rsp.echo_b        = s2.echo_b;
      rsp.echo_c        = s2.echo_c;
      rsp.voted_average = s2.negative ? quotient_neg : quotient;
   end

endmodule

FILE: design/tsv_checker.sv
// Port checker for the tolerance voter, bound to the top level.
`include "assert_macros.svh"

module tsv_checker
   import tsv_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic       rsp_held;
   logic       is_ok;
   logic       not_ok;
   logic       is_error;
   logic       avg_zero;
   logic       err_clean;
   logic [1:0] agree_count;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign is_ok       = rsp_valid && (rsp_payload.vote_status == VOTE_OK);
   assign not_ok      = rsp_valid && (rsp_payload.vote_status != VOTE_OK);
   assign is_error    = rsp_valid && (rsp_payload.vote_status == VOTE_SENSOR_ERROR);
   assign avg_zero    = (rsp_payload.voted_average == '0);
   assign agree_count = 2'($countones({rsp_payload.agree_a, rsp_payload.agree_b,
                                       rsp_payload.agree_c}));
   assign err_clean   = (agree_count == 2'd0) && avg_zero;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "valid dropped under stall")

   `ASSERT_NEXT(a_stable, clock, reset, rsp_held, $stable(rsp_payload), "payload moved in stall")

   `ASSERT_SAME(a_err_clean, clock, reset, is_error, err_clean, "sensor error not clean")

   `ASSERT_SAME(a_avg_zero, clock, reset, not_ok, avg_zero, "average without ok status")

   `ASSERT_SAME(a_ok_pair, clock, reset, is_ok, agree_count >= 2'd2, "ok without a majority")

endmodule

bind triple_sensor_tolerance_voter_unit tsv_checker u_tsv_checker (.*);

FILE: bench/tb_triple_sensor_tolerance_voter_unit.sv
// Self-checking testbench for the two-of-three tolerance voter and its tolerance register.
module tb_triple_sensor_tolerance_voter_unit
   import tsv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here if the results stop coming.
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SWEEP_ITEMS = 285;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state: our own copy of the tolerance register.
   logic [TOL_W-1:0] tolerance_setting = TOLERANCE_RESET;

   // Votes that the block owes us, oldest first.
   rsp_payload_type expected_votes[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;

   // Random gaps and stalls are on for most of the run; the last sweep phase
   // runs at full rate on both sides.
   bit idling_on = 1'b1;

   triple_sensor_tolerance_voter_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // 2 ns clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d votes outstanding", $time, expected_votes.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Result-side back-pressure. A burst of stalled cycles starts now
   // and then; stall_left counts the cycles after the first one.
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Two readings agree when their exact difference, taken in full integer
   // width so that nothing wraps, is no larger than the tolerance.
   function automatic bit within_tolerance(int x, int y, logic [TOL_W-1:0] tol);
      int diff;
      diff = x - y;
      if (diff < 0) diff = -diff;
      return diff <= int'(tol);
   endfunction

   // Works out the vote for one set of readings under the given tolerance.
   function automatic rsp_payload_type predict_vote(req_payload_type item,
                                                    logic [TOL_W-1:0] tol);
      rsp_payload_type vote;
      int  level[3];
      bit  present[3];
      bit  agrees[3];
      int  valid_count;
      int  agree_count;
      int  total;
      int  mean;
      level[0] = $signed(item.reading_a);
      level[1] = $signed(item.reading_b);
      level[2] = $signed(item.reading_c);
      present[0] = item.valid_a;
      present[1] = item.valid_b;
      present[2] = item.valid_c;
      valid_count = present[0] + present[1] + present[2];
      agree_count = 0;
      total = 0;
      mean = 0;
      agrees = '{0, 0, 0};
      if (valid_count < 2) begin
         vote.vote_status = VOTE_SENSOR_ERROR;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (present[i]) begin
               agrees[i] = (present[(i + 1) % 3] &&
                            within_tolerance(level[i], level[(i + 1) % 3], tol)) ||
                           (present[(i + 2) % 3] &&
                            within_tolerance(level[i], level[(i + 2) % 3], tol));
            end
            if (agrees[i]) begin
               total += level[i];
               agree_count++;
            end
         end
         if (agree_count >= 2) begin
            // Integer division truncates toward zero, as the block must.
            mean = total / agree_count;
            vote.vote_status = VOTE_OK;
         end else begin
            vote.vote_status = VOTE_DISAGREE;
         end
      end
      vote.agree_a = agrees[0];
      vote.agree_b = agrees[1];
      vote.agree_c = agrees[2];
      vote.echo_a = present[0] ? item.reading_a : '0;
      vote.echo_b = present[1] ? item.reading_b : '0;
      vote.echo_c = present[2] ? item.reading_c : '0;
      vote.voted_average = mean[READING_W-1:0];
      return vote;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_vote(input rsp_payload_type want, input rsp_payload_type got);
      check_field("vote_status", int'(want.vote_status), int'(got.vote_status));
      check_field("agree_a", want.agree_a, got.agree_a);
      check_field("agree_b", want.agree_b, got.agree_b);
      check_field("agree_c", want.agree_c, got.agree_c);
      check_field("echo_a", want.echo_a, got.echo_a);
      check_field("echo_b", want.echo_b, got.echo_b);
      check_field("echo_c", want.echo_c, got.echo_c);
      check_field("voted_average", want.voted_average, got.voted_average);
   endtask

   // Result monitor. Everything is sampled at the falling edge, where both
   // sides are stable, so the values seen are the ones that the next rising
   // edge will act on. A valid, unstalled result there is a transaction.
   always @(negedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_votes.size() == 0) begin
            $display("%0t: expected no result, got %p", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_votes.pop_front();
            compare_vote(want, rsp_payload);
         end
      end
   end

   // Offers one set of readings and returns at the rising edge that takes it.
   // It is entered at a rising edge; valid stays high straight into the next
   // call unless that call opens a gap, so valid never toggles within a step.
   task automatic send_readings(input req_payload_type item);
      bit taken;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) expected_votes.push_back(predict_vote(item, tolerance_setting));
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed vote has been checked. Each
   // transaction yields exactly one vote, so the block is idle afterwards.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_votes.size() != 0) @(posedge clock);
   endtask

   // One register access: a setup cycle, then the access cycle that
   // completes at the rising edge where pready is seen high.
   task automatic csr_access(input logic is_write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      bit done;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= ADDR_TOLERANCE;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = pready;
         rdata = prdata;
         @(posedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_tolerance_readback();
      logic [CSR_DATA_W-1:0] readback;
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(tolerance_setting)) begin
         $display("%0t: tolerance readback expected %0d, got %0d",
                  $time, tolerance_setting, readback);
         mismatch_count++;
      end
   endtask

   // Only the low bits of the written word reach the register; the rest is
   // dropped, and the predictor keeps the same bits.
   task automatic program_tolerance(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      drain_results();
      csr_access(1'b1, value, unused);
      tolerance_setting = value[TOL_W-1:0];
      check_tolerance_readback();
   endtask

   function automatic req_payload_type make_readings(int ra, bit va, int rb, bit vb,
                                                     int rc, bit vc);
      req_payload_type item;
      item.reading_a = ra[READING_W-1:0];
      item.valid_a = va;
      item.reading_b = rb[READING_W-1:0];
      item.valid_b = vb;
      item.reading_c = rc[READING_W-1:0];
      item.valid_c = vc;
      return item;
   endfunction

   function automatic int clamp_reading(int value);
      if (value > 32767) return 32767;
      if (value < -32768) return -32768;
      return value;
   endfunction

   // Random readings. Most sets sit within a few tolerances of one center,
   // so that agreement, partial agreement and disagreement all occur; some
   // centers hug the ends of the range, some sets are plain noise, and some
   // use only the extreme values. Each reading is valid four times in five.
   function automatic req_payload_type random_readings(logic [TOL_W-1:0] tol);
      int extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      int level[3];
      int center;
      int spread;
      int pick;
      pick = $urandom_range(0, 99);
      spread = 2 * int'(tol) + 1;
      if (pick < 15) begin
         for (int i = 0; i < 3; i++) level[i] = $signed(READING_W'($urandom));
      end else if (pick < 90) begin
         if (pick < 75)
            center = $signed(READING_W'($urandom));
         else if ($urandom_range(0, 1) == 1)
            center = 32767 - int'($urandom_range(0, spread));
         else
            center = -32768 + int'($urandom_range(0, spread));
         for (int i = 0; i < 3; i++)
            level[i] = clamp_reading(center + int'($urandom_range(0, 2 * spread)) - spread);
         // Now and then one reading wanders off entirely.
         if ($urandom_range(0, 4) == 0)
            level[$urandom_range(0, 2)] = $signed(READING_W'($urandom));
      end else begin
         for (int i = 0; i < 3; i++) level[i] = extremes[$urandom_range(0, 6)];
      end
      return make_readings(level[0], $urandom_range(0, 4) != 0,
                           level[1], $urandom_range(0, 4) != 0,
                           level[2], $urandom_range(0, 4) != 0);
   endfunction

   // Reset value of the tolerance, and agreement exactly at and just past it.
   task automatic test_tolerance_boundary();
      check_tolerance_readback();
      // A and B differ by exactly the tolerance, C is one step too far from B.
      send_readings(make_readings(100, 1, 110, 1, 121, 1));
      // Mean of two negative readings rounds toward zero: -3 / 2 is -1.
      send_readings(make_readings(-1, 1, -2, 1, 7, 0));
      // Agreement between the first and third reading only.
      send_readings(make_readings(-500, 1, 9000, 1, -490, 1));
   endtask

   // Fewer than two valid readings: the echoes still show what was valid.
   task automatic test_sensor_error();
      send_readings(make_readings(1234, 0, -1234, 0, 77, 0));
      send_readings(make_readings(1234, 1, 1234, 0, 1234, 0));
      send_readings(make_readings(-32768, 0, -32768, 1, -32768, 0));
      send_readings(make_readings(32767, 0, 32767, 0, 32767, 1));
   endtask

   // Valid readings with no pair inside the tolerance.
   task automatic test_disagree();
      send_readings(make_readings(100, 1, 111, 1, -5000, 1));
      send_readings(make_readings(0, 1, 40, 0, 11, 1));
      send_readings(make_readings(-32768, 1, 32767, 1, 0, 0));
   endtask

   // Largest and smallest tolerance against the ends of the reading range.
   task automatic test_range_extremes();
      program_tolerance(32'd32767);
      send_readings(make_readings(32767, 1, 32767, 1, 32767, 1));
      send_readings(make_readings(-32768, 1, -32768, 1, -32768, 1));
      // Only B and C lie within 32767 of each other.
      send_readings(make_readings(-32768, 1, 32767, 1, 0, 1));
      // A and B agree, their mean -16384.5 truncates to -16384.
      send_readings(make_readings(-32768, 1, -1, 1, 32767, 1));
      program_tolerance(32'd0);
      send_readings(make_readings(5, 1, 5, 1, 5, 1));
      send_readings(make_readings(5, 1, 6, 1, 5, 1));
      send_readings(make_readings(5, 1, 6, 1, 7, 1));
      send_readings(make_readings(-7, 1, -7, 1, -8, 1));
      send_readings(make_readings(32767, 1, 32766, 1, -32768, 0));
   endtask

   // Random sets under a series of tolerances: both extremes, small ones,
   // a random one, and a write with junk above the register's width. The
   // last phase runs with no gaps and no stalls.
   task automatic test_random_sweep();
      logic [CSR_DATA_W-1:0] settings[6];
      settings[0] = 32'd0;
      settings[1] = 32'd32767;
      settings[2] = 32'd1;
      settings[3] = CSR_DATA_W'($urandom_range(2, 60));
      settings[4] = CSR_DATA_W'($urandom_range(0, 32767));
      settings[5] = {17'($urandom) | 17'd1, 15'($urandom_range(0, 200))};
      for (int phase = 0; phase < 6; phase++) begin
         program_tolerance(settings[phase]);
         if (phase == 5) idling_on = 1'b0;
         repeat (SWEEP_ITEMS) send_readings(random_readings(tolerance_setting));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_tolerance_boundary();
      test_sensor_error();
      test_disagree();
      test_range_extremes();
      test_random_sweep();
      drain_results();
      // The pipeline is three stages deep; give a stray extra result the
      // chance to show up before the verdict.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: triple_sensor_tolerance_voter_unit.f
+incdir+design
design/tsv_pkg.sv
design/tsv_pair_lane.sv
design/tsv_merge.sv
design/tsv_scale.sv
design/triple_sensor_tolerance_voter_unit.sv
design/tsv_checker.sv
bench/tb_triple_sensor_tolerance_voter_unit.sv
